>>> rtl/rhs_pkg.sv
// shared types and constants for the rail homing and shuttle block
// no dependencies; imported by every module under rtl
`default_nettype none
package rhs_pkg;

  localparam int POSITION_BITS  = 24;
  localparam int SPEED_BITS     = 14;
  localparam int CFG_BITS       = 13;
  localparam int TRIP_BITS      = 16;
  localparam int CFG_INDEX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEEK_SPEED  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CREEP_SPEED = CFG_INDEX_BITS'(1);

  localparam logic [CFG_BITS-1:0]  SEEK_SPEED_RESET  = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0]  CREEP_SPEED_RESET = CFG_BITS'(100);
  localparam logic [TRIP_BITS-1:0] TRIPS_RESET       = TRIP_BITS'(1);

  typedef enum logic [1:0] {
    HOME_SEEK_LEFT,
    HOME_CREEP_LEFT_OFF,
    HOME_SEEK_RIGHT,
    HOME_CREEP_RIGHT_OFF
  } home_step_t;

  typedef struct packed {
    logic                            left_switch;
    logic                            right_switch;
    logic signed [POSITION_BITS-1:0] position;
    logic                            enable;
  } item_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0]    speed_command;
    logic signed [POSITION_BITS-1:0] position_target;
    logic                            moving_right;
    logic                            motor_cut;
    logic                            clear_position;
    logic                            homed;
    logic [TRIP_BITS-1:0]            trip_count;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/rhs_in_reg.sv
// input register stage: holds one accepted item until the control logic takes it
// depends on rhs_pkg
`default_nettype none
module rhs_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rhs_pkg::item_t item_in,
  input  logic           advance,
  output logic           step,
  output rhs_pkg::item_t item_out
);
  import rhs_pkg::*;

  logic  held_valid;
  item_t held;

  assign step     = held_valid && advance;
  assign in_ready = !held_valid || advance;
  assign item_out = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= item_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rhs_ctrl.sv
// homing sequencer, shuttle logic, configuration and state registers
// depends on rhs_pkg
`default_nettype none
module rhs_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [rhs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rhs_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 step,
  input  rhs_pkg::item_t                       item,
  output rhs_pkg::result_t                     res
);
  import rhs_pkg::*;

  logic [CFG_BITS-1:0] seek_speed;
  logic [CFG_BITS-1:0] creep_speed;

  home_step_t                      homing_step, homing_step_next;
  logic                            homed_flag, homed_flag_next;
  logic                            direction_right, direction_right_next;
  logic signed [POSITION_BITS-1:0] track_length, track_length_next;
  logic                            rebound_pending, rebound_pending_next;
  logic                            rebound_cut, rebound_cut_next;
  logic [TRIP_BITS-1:0]            trips, trips_next;
  logic signed [SPEED_BITS-1:0]    speed_reg, speed_reg_next;
  logic signed [POSITION_BITS-1:0] target_reg, target_reg_next;
  logic                            clear;

  logic signed [SPEED_BITS-1:0] seek_right, seek_left, creep_right, creep_left;
  assign seek_right  = SPEED_BITS'({1'b0, seek_speed});
  assign creep_right = SPEED_BITS'({1'b0, creep_speed});
  assign seek_left   = -seek_right;
  assign creep_left  = -creep_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      seek_speed  <= SEEK_SPEED_RESET;
      creep_speed <= CREEP_SPEED_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_SEEK_SPEED) begin
        seek_speed <= cfg_data;
      end
      if (cfg_index == CFG_CREEP_SPEED) begin
        creep_speed <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      homing_step     <= HOME_SEEK_LEFT;
      homed_flag      <= 1'b0;
      direction_right <= 1'b0;
      track_length    <= '0;
      rebound_pending <= 1'b0;
      rebound_cut     <= 1'b0;
      trips           <= TRIPS_RESET;
      speed_reg       <= '0;
      target_reg      <= '0;
    end else if (step) begin
      homing_step     <= homing_step_next;
      homed_flag      <= homed_flag_next;
      direction_right <= direction_right_next;
      track_length    <= track_length_next;
      rebound_pending <= rebound_pending_next;
      rebound_cut     <= rebound_cut_next;
      trips           <= trips_next;
      speed_reg       <= speed_reg_next;
      target_reg      <= target_reg_next;
    end
  end

  always_comb begin
    homing_step_next     = homing_step;
    homed_flag_next      = homed_flag;
    direction_right_next = direction_right;
    track_length_next    = track_length;
    rebound_pending_next = rebound_pending;
    rebound_cut_next     = rebound_cut;
    trips_next           = trips;
    speed_reg_next       = speed_reg;
    target_reg_next      = target_reg;
    clear                = 1'b0;

    if (!item.enable) begin
      homed_flag_next = 1'b0;
    end else if (homed_flag) begin
      // heading left: rebound off the left switch
      if (!direction_right_next) begin
        target_reg_next = '0;
        if (item.left_switch) begin
          rebound_pending_next = 1'b1;
          rebound_cut_next     = 1'b1;
        end
        if (rebound_pending_next && !item.left_switch) begin
          trips_next           = trips + TRIP_BITS'(1);
          direction_right_next = 1'b1;
          target_reg_next      = track_length_next;
          clear                = 1'b1;
          rebound_pending_next = 1'b0;
          rebound_cut_next     = 1'b0;
        end
      end
      // heading right, possibly just turned this tick
      if (direction_right_next) begin
        target_reg_next = track_length_next;
        if (item.right_switch) begin
          rebound_pending_next = 1'b1;
          rebound_cut_next     = 1'b1;
        end
        if (rebound_pending_next && !item.right_switch) begin
          direction_right_next = 1'b0;
          target_reg_next      = '0;
          track_length_next    = item.position;
          rebound_pending_next = 1'b0;
          rebound_cut_next     = 1'b0;
        end
      end
      if (rebound_pending_next) begin
        rebound_cut_next = 1'b1;
      end
    end else begin
      case (homing_step)
        HOME_SEEK_LEFT: begin
          if (item.left_switch) begin
            speed_reg_next   = '0;
            homing_step_next = HOME_CREEP_LEFT_OFF;
          end else begin
            speed_reg_next = seek_left;
          end
        end
        HOME_CREEP_LEFT_OFF: begin
          if (item.left_switch) begin
            speed_reg_next = creep_right;
          end else begin
            speed_reg_next   = '0;
            clear            = 1'b1;
            homing_step_next = HOME_SEEK_RIGHT;
          end
        end
        HOME_SEEK_RIGHT: begin
          if (item.right_switch) begin
            speed_reg_next   = '0;
            homing_step_next = HOME_CREEP_RIGHT_OFF;
          end else begin
            speed_reg_next = seek_right;
          end
        end
        HOME_CREEP_RIGHT_OFF: begin
          if (item.right_switch) begin
            speed_reg_next = creep_left;
          end else begin
            speed_reg_next       = '0;
            track_length_next    = item.position;
            homing_step_next     = HOME_SEEK_LEFT;
            homed_flag_next      = 1'b1;
            direction_right_next = 1'b0;
            target_reg_next      = '0;
          end
        end
        default: begin
          homing_step_next = HOME_SEEK_LEFT;
        end
      endcase
    end
  end

  assign res.speed_command   = speed_reg_next;
  assign res.position_target = target_reg_next;
  assign res.moving_right    = direction_right_next;
  assign res.motor_cut       = rebound_cut_next;
  assign res.clear_position  = clear;
  assign res.homed           = homed_flag_next;
  assign res.trip_count      = trips_next;

`ifndef SYNTHESIS
  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(homing_step) && $stable(trips) && $stable(track_length))
    else $error("state moved without an item");

  a_trip_inc: assert property (@(posedge clk) disable iff (rst)
    step |=> (trips == $past(trips)) || (trips == $past(trips) + TRIP_BITS'(1)))
    else $error("trip count jumped");

  // the right switch may already be pressed in the tick that turns right
  a_clear_dir: assert property (@(posedge clk) disable iff (rst)
    (step && res.clear_position && res.homed) |-> res.moving_right)
    else $error("position clear at left end without turning right");

  a_disabled: assert property (@(posedge clk) disable iff (rst)
    (step && !item.enable) |-> !res.homed && !res.clear_position)
    else $error("disabled tick reported homed or clear");
`endif

endmodule
`default_nettype wire

>>> rtl/rhs_out_reg.sv
// result register: holds one result until the consumer takes it
// depends on rhs_pkg
`default_nettype none
module rhs_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rhs_pkg::result_t res_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output rhs_pkg::result_t res_out
);
  import rhs_pkg::*;

  result_t held;

  assign can_load = !out_valid || out_ready;
  assign res_out  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rail_homing_and_shuttle.sv
// Rail homing and shuttle controller: one result per control tick. An item
// is taken into an input register, its tick is evaluated against the
// homing/shuttle state and written to a result register; a new item is
// accepted every cycle while the result register drains. Configuration
// writes (seek and creep speed) are always accepted and take effect for
// the next evaluated item.
// depends on rhs_pkg, rhs_in_reg, rhs_ctrl, rhs_out_reg
`default_nettype none
module rail_homing_and_shuttle (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [rhs_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [rhs_pkg::CFG_BITS-1:0]             cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     left_switch,
  input  logic                                     right_switch,
  input  logic signed [rhs_pkg::POSITION_BITS-1:0] position,
  input  logic                                     enable,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [rhs_pkg::SPEED_BITS-1:0]    speed_command,
  output logic signed [rhs_pkg::POSITION_BITS-1:0] position_target,
  output logic                                     moving_right,
  output logic                                     motor_cut,
  output logic                                     clear_position,
  output logic                                     homed,
  output logic [rhs_pkg::TRIP_BITS-1:0]            trip_count
);
  import rhs_pkg::*;

  item_t   item_in, item;
  result_t res, res_out;
  logic    step, can_load;

  assign cfg_ready = 1'b1;

  assign item_in.left_switch  = left_switch;
  assign item_in.right_switch = right_switch;
  assign item_in.position     = position;
  assign item_in.enable       = enable;

  rhs_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_in  (item_in),
    .advance  (can_load),
    .step     (step),
    .item_out (item)
  );

  rhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .res       (res)
  );

  rhs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign speed_command   = res_out.speed_command;
  assign position_target = res_out.position_target;
  assign moving_right    = res_out.moving_right;
  assign motor_cut       = res_out.motor_cut;
  assign clear_position  = res_out.clear_position;
  assign homed           = res_out.homed;
  assign trip_count      = res_out.trip_count;

`ifndef SYNTHESIS
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result side is free");
`endif

endmodule
`default_nettype wire

>>> test/rail_homing_and_shuttle_test.sv
// testbench for rail_homing_and_shuttle: directed table, then random ticks checked
// against a local predictor of the homing and shuttle logic; depends on rhs_pkg
`timescale 1ns / 100ps
module rail_homing_and_shuttle_test;
  import rhs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 60;
  localparam int TAIL_CYCLES    = 4;

  localparam logic signed [POSITION_BITS-1:0] POS_MAX  = 24'h7FFFFF;
  localparam logic signed [POSITION_BITS-1:0] POS_MIN  = 24'h800000;
  localparam logic signed [POSITION_BITS-1:0] POS_ONES = 24'hFFFFFF;
  localparam logic [CFG_BITS-1:0]             SPEED_HIGH = 13'd5000;

  typedef struct packed {
    item_t   it;
    logic    fixed;
    result_t want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic left_switch;
  logic right_switch;
  logic signed [POSITION_BITS-1:0] position;
  logic enable;
  logic out_valid;
  logic out_ready;
  logic signed [SPEED_BITS-1:0] speed_command;
  logic signed [POSITION_BITS-1:0] position_target;
  logic moving_right;
  logic motor_cut;
  logic clear_position;
  logic homed;
  logic [TRIP_BITS-1:0] trip_count;

  rail_homing_and_shuttle dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_switch(left_switch), .right_switch(right_switch), .position(position),
    .enable(enable),
    .out_valid(out_valid), .out_ready(out_ready),
    .speed_command(speed_command), .position_target(position_target),
    .moving_right(moving_right), .motor_cut(motor_cut), .clear_position(clear_position),
    .homed(homed), .trip_count(trip_count)
  );

  // predictor copy of the controller state and speed registers
  home_step_t                      step_m;
  logic                            homed_m;
  logic                            dir_right_m;
  logic signed [POSITION_BITS-1:0] track_m;
  logic                            pending_m;
  logic                            cut_m;
  logic [TRIP_BITS-1:0]            trips_m;
  logic signed [SPEED_BITS-1:0]    speed_m;
  logic signed [POSITION_BITS-1:0] target_m;
  logic [CFG_BITS-1:0]             seek_cfg;
  logic [CFG_BITS-1:0]             creep_cfg;

  result_t expected_ticks[$];
  int      mismatches = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_asks = 0;

  // l, r, position, enable, fixed, expected
  row_t directed_rows [22] = '{
    '{'{1'b0, 1'b0, 24'sd0, 1'b0}, 1'b1,
      '{14'sd0, 24'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{'{1'b0, 1'b0, POS_ONES, 1'b1}, 1'b1,
      '{-14'sd1000, 24'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{'{1'b1, 1'b1, POS_MAX, 1'b1}, 1'b1,
      '{14'sd0, 24'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{'{1'b1, 1'b0, POS_MIN, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0, 24'sd0, 1'b1}, 1'b1,
      '{14'sd100, 24'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{'{1'b0, 1'b1, POS_MIN, 1'b1}, 1'b1,
      '{14'sd0, 24'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{1'b1, 1'b0, 24'h123456, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b1, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b0, POS_MAX, 1'b1}, 1'b1,
      '{14'sd0, 24'sd0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1}},
    '{'{1'b0, 1'b1, POS_MAX, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b1, 24'h00ABCD, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b0, POS_MIN, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b1, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b0, POS_ONES, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b0, 24'sd0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0, 24'h555555, 1'b1}, 1'b0, '0},
    '{'{1'b1, 1'b1, 24'h2AAAAA, 1'b1}, 1'b0, '0}
  };

  function automatic result_t advance_rail(item_t it);
    result_t r;
    logic    clr;
    clr = 1'b0;
    if (!it.enable) begin
      homed_m = 1'b0;
    end else if (homed_m) begin
      if (!dir_right_m) begin
        target_m = '0;
        if (it.left_switch) begin
          pending_m = 1'b1;
          cut_m = 1'b1;
        end
        if (pending_m && !it.left_switch) begin
          trips_m = trips_m + 1'b1;
          dir_right_m = 1'b1;
          target_m = track_m;
          clr = 1'b1;
          pending_m = 1'b0;
          cut_m = 1'b0;
        end
      end
      // a fresh rightward run looks at the right switch in the same tick
      if (dir_right_m) begin
        target_m = track_m;
        if (it.right_switch) begin
          pending_m = 1'b1;
          cut_m = 1'b1;
        end
        if (pending_m && !it.right_switch) begin
          dir_right_m = 1'b0;
          target_m = '0;
          track_m = it.position;
          pending_m = 1'b0;
          cut_m = 1'b0;
        end
      end
      if (pending_m) cut_m = 1'b1;
    end else begin
      case (step_m)
        HOME_SEEK_LEFT: begin
          if (it.left_switch) begin
            speed_m = '0;
            step_m = HOME_CREEP_LEFT_OFF;
          end else begin
            speed_m = -$signed({1'b0, seek_cfg});
          end
        end
        HOME_CREEP_LEFT_OFF: begin
          if (it.left_switch) begin
            speed_m = $signed({1'b0, creep_cfg});
          end else begin
            speed_m = '0;
            clr = 1'b1;
            step_m = HOME_SEEK_RIGHT;
          end
        end
        HOME_SEEK_RIGHT: begin
          if (it.right_switch) begin
            speed_m = '0;
            step_m = HOME_CREEP_RIGHT_OFF;
          end else begin
            speed_m = $signed({1'b0, seek_cfg});
          end
        end
        default: begin
          if (it.right_switch) begin
            speed_m = -$signed({1'b0, creep_cfg});
          end else begin
            speed_m = '0;
            track_m = it.position;
            step_m = HOME_SEEK_LEFT;
            homed_m = 1'b1;
            dir_right_m = 1'b0;
            target_m = '0;
          end
        end
      endcase
    end
    r.speed_command   = speed_m;
    r.position_target = target_m;
    r.moving_right    = dir_right_m;
    r.motor_cut       = cut_m;
    r.clear_position  = clr;
    r.homed           = homed_m;
    r.trip_count      = trips_m;
    return r;
  endfunction

  // mostly plausible switch traffic at the end being approached, some noise
  function automatic item_t pick_item();
    item_t it;
    logic  near_right;
    logic  pressed;
    logic  stray;
    int    roll;
    near_right = homed_m ? dir_right_m
                         : (step_m == HOME_SEEK_RIGHT || step_m == HOME_CREEP_RIGHT_OFF);
    it.enable = ($urandom_range(0, 99) >= 3);
    if ($urandom_range(0, 99) < 20) begin
      it.left_switch  = 1'($urandom_range(0, 1));
      it.right_switch = 1'($urandom_range(0, 1));
    end else begin
      pressed = ($urandom_range(0, 99) < 45);
      stray   = ($urandom_range(0, 99) < 8);
      it.left_switch  = near_right ? stray : pressed;
      it.right_switch = near_right ? pressed : stray;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) it.position = POS_MAX;
    else if (roll < 8) it.position = POS_MIN;
    else if (roll < 11) it.position = '0;
    else if (roll < 14) it.position = POS_ONES;
    else it.position = POSITION_BITS'($urandom);
    return it;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (expected_ticks.size() == 0) begin
      mismatches++;
      $display("%0t: result with no item waiting", $time);
      return;
    end
    want = expected_ticks.pop_front();
    compare_field("speed_command", want.speed_command, speed_command);
    compare_field("position_target", want.position_target, position_target);
    compare_field("moving_right", want.moving_right, moving_right);
    compare_field("motor_cut", want.motor_cut, motor_cut);
    compare_field("clear_position", want.clear_position, clear_position);
    compare_field("homed", want.homed, homed);
    compare_field("trip_count", want.trip_count, trip_count);
  endtask

  task automatic send_item(input item_t it, input logic fixed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    left_switch  <= it.left_switch;
    right_switch <= it.right_switch;
    position     <= it.position;
    enable       <= it.enable;
    do @(posedge clk); while (!in_ready);
    predicted = advance_rail(it);
    expected_ticks.push_back(fixed ? want : predicted);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(pick_item(), 1'b0, '0);
  endtask

  task automatic drain_results(input int tail);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_speeds(input logic [CFG_BITS-1:0] seek,
                              input logic [CFG_BITS-1:0] creep);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SEEK_SPEED;
    cfg_data  <= seek;
    do @(posedge clk); while (!cfg_ready);
    seek_cfg = seek;
    cfg_index <= CFG_CREEP_SPEED;
    cfg_data  <= creep;
    do @(posedge clk); while (!cfg_ready);
    creep_cfg = creep;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: checks every accepted item, random stalls, long hold on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result();
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
      if (stalled >= WATCHDOG_LIMIT) begin
        $display("rail_homing_and_shuttle test failed");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_SEEK_SPEED;
    cfg_data     = '0;
    in_valid     = 1'b0;
    left_switch  = 1'b0;
    right_switch = 1'b0;
    position     = '0;
    enable       = 1'b0;
    step_m       = HOME_SEEK_LEFT;
    homed_m      = 1'b0;
    dir_right_m  = 1'b0;
    track_m      = '0;
    pending_m    = 1'b0;
    cut_m        = 1'b0;
    trips_m      = TRIPS_RESET;
    speed_m      = '0;
    target_m     = '0;
    seek_cfg     = SEEK_SPEED_RESET;
    creep_cfg    = CREEP_SPEED_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset speeds, sender idles lightly, receiver heavily
    send_idle = 31;
    recv_idle = 72;
    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].want);
    run_random(200);
    drain_results(TAIL_CYCLES);

    write_speeds('0, SPEED_HIGH);
    send_idle = 72;
    recv_idle = 31;
    run_random(110);
    // sender holds back until every item has come out
    drain_results(0);
    run_random(110);
    drain_results(TAIL_CYCLES);

    write_speeds(SPEED_HIGH, '0);
    send_idle = 0;
    recv_idle = 0;
    // receiver holds off while items keep coming, so the input backs up
    hold_asks++;
    run_random(100);
    drain_results(TAIL_CYCLES);

    write_speeds(CFG_BITS'($urandom_range(0, 5000)), CFG_BITS'($urandom_range(0, 5000)));
    run_random(110);
    drain_results(TAIL_CYCLES);

    if (mismatches == 0) begin
      $display("rail_homing_and_shuttle test passed");
    end else begin
      $display("rail_homing_and_shuttle test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rhs_pkg.sv
rtl/rhs_in_reg.sv
rtl/rhs_ctrl.sv
rtl/rhs_out_reg.sv
rtl/rail_homing_and_shuttle.sv
test/rail_homing_and_shuttle_test.sv
